// ===== sv/cpio_pkg.sv =====
// Package for the cpio newc stream parser: types, constants and decode helpers.
package cpio_pkg;

	localparam int ALIGN_BYTES_DEF = 4;
	localparam int HEADER_LEN      = 110;
	localparam int MAGIC_LEN       = 6;
	localparam int TRAILER_LEN     = 10;
	localparam int NUM_SLOTS       = 7;
	localparam int FIELD_W         = 32;
	localparam int SNL_W           = 4;
	localparam int TDATA_W         = 8 + NUM_SLOTS * FIELD_W;
	localparam int TUSER_W         = 5;

	localparam logic [2:0] SLOT_NONE      = 3'd7;
	localparam logic [2:0] SLOT_DATA_SIZE = 3'd5;
	localparam logic [2:0] SLOT_NAME_SIZE = 3'd6;
	localparam logic [7:0] SLASH_CHAR     = 8'h2F;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_NAMEPAD,
		PH_DATA,
		PH_DATAPAD,
		PH_ENDED
	} phase_t;

	typedef enum logic [2:0] {
		RGN_HEADER,
		RGN_SLASH,
		RGN_NAME_CHAR,
		RGN_NAME_TERM,
		RGN_NAME_PAD,
		RGN_DATA,
		RGN_DATA_PAD,
		RGN_AFTER_END
	} region_t;

	// ASCII hex digit to value, anything else to zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	// header field number to kept slot
	function automatic logic [2:0] slot_of_field(input logic [3:0] f);
		logic [2:0] s;
		case (f)
			4'd0:    s = 3'd0;
			4'd1:    s = 3'd1;
			4'd2:    s = 3'd2;
			4'd3:    s = 3'd3;
			4'd5:    s = 3'd4;
			4'd6:    s = SLOT_DATA_SIZE;
			4'd11:   s = SLOT_NAME_SIZE;
			default: s = SLOT_NONE;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] trailer_char(input logic [SNL_W-1:0] i);
		logic [7:0] c;
		case (i)
			4'd0:    c = 8'h54; // T
			4'd1:    c = 8'h52; // R
			4'd2:    c = 8'h41; // A
			4'd3:    c = 8'h49; // I
			4'd4:    c = 8'h4C; // L
			4'd5:    c = 8'h45; // E
			4'd6:    c = 8'h52; // R
			4'd7:    c = 8'h21; // !
			4'd8:    c = 8'h21;
			4'd9:    c = 8'h21;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/cpio_newc_stream_parser.sv =====
// cpio newc stream parser: tags each archive byte with its region and decodes headers.
//
// Input stream s_axis carries one archive byte per transaction, the first byte
// of the archive on an ALIGN_BYTES boundary. Output stream m_axis returns one
// transaction per input byte: the byte itself, the decoded header fields of the
// current entry, the region code and header/end flags in tuser, and tlast on
// the final byte of each region.
// Each accepted byte is registered and appears on m_axis in the cycle after its
// handshake. Throughput is one byte per cycle while m_axis is not stalled; all
// parsing for a byte is done between the input handshake and the output register.
// s_axis_tready is high while the output register is empty or being drained,
// so a stalled receiver holds m_axis stable and backpressures the source after
// one buffered transaction.
// Reset puts the parser at the start of a header with all decoded fields zero
// and the output empty. After the trailer entry every byte is tagged
// after-end until the next reset.
module cpio_newc_stream_parser #(
	parameter int ALIGN_BYTES = cpio_pkg::ALIGN_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // byte_in
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// byte_out, inode, file_mode, owner_id, group_id, mod_time, data_size, name_size
	output logic [cpio_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [cpio_pkg::TUSER_W-1:0] m_axis_tuser,  // region[2:0], header_valid, end_of_archive
	output logic                         m_axis_tlast   // last_of_region
);

	localparam int POS_W = (ALIGN_BYTES > 2) ? $clog2(ALIGN_BYTES) : 1;
	localparam logic [POS_W:0] ALIGN_L = (POS_W + 1)'(ALIGN_BYTES);
	localparam logic [cpio_pkg::SNL_W-1:0] SNL_TRAILER = cpio_pkg::SNL_W'(cpio_pkg::TRAILER_LEN);
	localparam logic [cpio_pkg::SNL_W-1:0] SNL_MAX = cpio_pkg::SNL_W'(cpio_pkg::TRAILER_LEN + 1);
	localparam logic [6:0] HDR_FIRST_DIGIT = 7'(cpio_pkg::MAGIC_LEN);
	localparam logic [6:0] HDR_LAST = 7'(cpio_pkg::HEADER_LEN - 1);

	cpio_pkg::phase_t           phase_q, phase_d;
	logic [6:0]                 hidx_q, hidx_d;
	logic [31:0]                acc_q, acc_d;
	logic [31:0]                df_q [cpio_pkg::NUM_SLOTS];
	logic [31:0]                df_d [cpio_pkg::NUM_SLOTS];
	logic [31:0]                rem_q, rem_d;
	logic [POS_W-1:0]           pos_q, pos_d;
	logic                       strip_q, strip_d;
	logic [cpio_pkg::SNL_W-1:0] snl_q, snl_d;
	logic                       tm_q, tm_d;

	logic [7:0]                 byte_q;
	logic                       out_valid_q;
	cpio_pkg::region_t          region_q, region_d;
	logic                       last_q, last_d;
	logic                       hv_q, hv_d;
	logic                       eoa_q, eoa_d;

	logic                       accept;
	logic [POS_W:0]             pos_inc;
	logic [6:0]                 rel;
	logic [2:0]                 slot;
	logic                       to_namepad, to_data, to_datapad, to_end;
	logic [7:0]                 b;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	assign pos_inc = {1'b0, pos_q} + (POS_W + 1)'(1);
	assign pos_d   = (pos_inc >= ALIGN_L) ? '0 : pos_inc[POS_W-1:0];
	assign rel     = hidx_q - HDR_FIRST_DIGIT;

	always_comb begin
		phase_d    = phase_q;
		hidx_d     = hidx_q;
		acc_d      = acc_q;
		df_d       = df_q;
		rem_d      = rem_q;
		strip_d    = strip_q;
		snl_d      = snl_q;
		tm_d       = tm_q;
		region_d   = cpio_pkg::RGN_AFTER_END;
		last_d     = 1'b0;
		hv_d       = 1'b0;
		eoa_d      = 1'b0;
		slot       = cpio_pkg::SLOT_NONE;
		to_namepad = 1'b0;
		to_data    = 1'b0;
		to_datapad = 1'b0;
		to_end     = 1'b0;

		case (phase_q)
			cpio_pkg::PH_HEADER: begin
				region_d = cpio_pkg::RGN_HEADER;
				if (hidx_q >= HDR_FIRST_DIGIT) begin
					acc_d = {acc_q[27:0], cpio_pkg::hex_value(b)};
					if (rel[2:0] == 3'd7) begin
						slot = cpio_pkg::slot_of_field(rel[6:3]);
						if (slot != cpio_pkg::SLOT_NONE) begin
							df_d[slot] = acc_d;
						end
					end
				end
				if (hidx_q >= HDR_LAST) begin
					last_d  = 1'b1;
					hv_d    = 1'b1;
					hidx_d  = '0;
					strip_d = 1'b1;
					snl_d   = '0;
					tm_d    = (df_d[cpio_pkg::SLOT_NAME_SIZE] != 32'd0);
					if (df_d[cpio_pkg::SLOT_NAME_SIZE] != 32'd0) begin
						phase_d = cpio_pkg::PH_NAME;
						rem_d   = df_d[cpio_pkg::SLOT_NAME_SIZE];
					end else begin
						to_namepad = 1'b1;
					end
				end else begin
					hidx_d = hidx_q + 7'd1;
				end
			end
			cpio_pkg::PH_NAME: begin
				if (rem_q <= 32'd1) begin
					// final name byte is the terminator whatever its value
					region_d = cpio_pkg::RGN_NAME_TERM;
					last_d   = 1'b1;
					if (!(tm_q && snl_q == SNL_TRAILER && b == 8'h00)) begin
						tm_d = 1'b0;
					end
					if (snl_q != SNL_MAX) begin
						snl_d = snl_q + 1'b1;
					end
					rem_d      = '0;
					to_namepad = 1'b1;
				end else begin
					if (strip_q && b == cpio_pkg::SLASH_CHAR) begin
						region_d = cpio_pkg::RGN_SLASH;
					end else begin
						strip_d  = 1'b0;
						region_d = cpio_pkg::RGN_NAME_CHAR;
						if (snl_q >= SNL_TRAILER || b != cpio_pkg::trailer_char(snl_q)) begin
							tm_d = 1'b0;
						end
						if (snl_q != SNL_MAX) begin
							snl_d = snl_q + 1'b1;
						end
					end
					last_d = (rem_q == 32'd2);
					rem_d  = rem_q - 32'd1;
				end
			end
			cpio_pkg::PH_NAMEPAD: begin
				region_d = cpio_pkg::RGN_NAME_PAD;
				if (pos_d == '0) begin
					last_d  = 1'b1;
					to_data = 1'b1;
				end
			end
			cpio_pkg::PH_DATA: begin
				region_d = cpio_pkg::RGN_DATA;
				if (rem_q <= 32'd1) begin
					last_d     = 1'b1;
					rem_d      = '0;
					to_datapad = 1'b1;
				end else begin
					rem_d = rem_q - 32'd1;
				end
			end
			cpio_pkg::PH_DATAPAD: begin
				region_d = cpio_pkg::RGN_DATA_PAD;
				if (pos_d == '0) begin
					last_d = 1'b1;
					to_end = 1'b1;
				end
			end
			default: begin
				region_d = cpio_pkg::RGN_AFTER_END;
			end
		endcase

		// empty regions fall through to the next one in the same byte
		if (to_namepad) begin
			if (pos_d != '0) begin
				phase_d = cpio_pkg::PH_NAMEPAD;
			end else begin
				to_data = 1'b1;
			end
		end
		if (to_data) begin
			if (df_d[cpio_pkg::SLOT_DATA_SIZE] != 32'd0) begin
				phase_d = cpio_pkg::PH_DATA;
				rem_d   = df_d[cpio_pkg::SLOT_DATA_SIZE];
			end else begin
				to_datapad = 1'b1;
			end
		end
		if (to_datapad) begin
			if (pos_d != '0) begin
				phase_d = cpio_pkg::PH_DATAPAD;
			end else begin
				to_end = 1'b1;
			end
		end
		if (to_end) begin
			if (tm_d) begin
				phase_d = cpio_pkg::PH_ENDED;
				eoa_d   = 1'b1;
			end else begin
				phase_d = cpio_pkg::PH_HEADER;
				hidx_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cpio_pkg::PH_HEADER;
			hidx_q      <= '0;
			acc_q       <= '0;
			for (int i = 0; i < cpio_pkg::NUM_SLOTS; i++) begin
				df_q[i] <= '0;
			end
			rem_q       <= '0;
			pos_q       <= '0;
			strip_q     <= 1'b1;
			snl_q       <= '0;
			tm_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				hidx_q  <= hidx_d;
				acc_q   <= acc_d;
				df_q    <= df_d;
				rem_q   <= rem_d;
				pos_q   <= pos_d;
				strip_q <= strip_d;
				snl_q   <= snl_d;
				tm_q    <= tm_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q   <= b;
			region_q <= region_d;
			last_q   <= last_d;
			hv_q     <= hv_d;
			eoa_q    <= eoa_d;
		end
	end

	// decoded fields change only on accept, so the live registers match the held result
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {df_q[6], df_q[5], df_q[4], df_q[3], df_q[2], df_q[1], df_q[0],
		byte_q};
	assign m_axis_tuser  = {eoa_q, hv_q, region_q};
	assign m_axis_tlast  = last_q;

endmodule

// ===== tb/tb_cpio_newc_stream_parser.sv =====
// Self-checking testbench for the cpio newc stream parser: directed entries, random archive, end.
`timescale 1ns / 1ps

module tb_cpio_newc_stream_parser;

	localparam int ALIGN         = 4;
	localparam int HDR_BYTES     = 110;
	localparam int MAGIC_BYTES   = 6;
	localparam int TRAILER_CHARS = 10;
	localparam int LIMIT_CYCLES  = 300000;
	localparam int RANDOM_BYTES  = 100;
	localparam logic [7:0]  SLASH        = 8'h2F;
	localparam logic [79:0] TRAILER_NAME = "TRAILER!!!";
	localparam logic [47:0] NEWC_MAGIC   = "070701";

	// header field numbers in stream order
	localparam int F_INO      = 0;
	localparam int F_MODE     = 1;
	localparam int F_UID      = 2;
	localparam int F_GID      = 3;
	localparam int F_NLINK    = 4;
	localparam int F_MTIME    = 5;
	localparam int F_FILESIZE = 6;
	localparam int F_NAMESIZE = 11;
	localparam int F_COUNT    = 13;
	// reported slots
	localparam int SL_DATA = 5;
	localparam int SL_NAME = 6;

	typedef enum logic [1:0] {CASE_UPPER, CASE_LOWER, CASE_MIXED} digit_case_t;
	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic [7:0]        data;
		cpio_pkg::region_t region;
		logic              last;
		logic              hv;
		logic              eoa;
		logic [6:0][31:0]  fld;
	} byte_tag_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// byte_out, inode, mode, uid, gid, mtime, data_size, name_size
	logic [cpio_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [cpio_pkg::TUSER_W-1:0] m_axis_tuser;  // region[2:0], header_valid, end_of_archive
	logic m_axis_tlast;                          // last_of_region

	cpio_newc_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// parser state as predicted
	cpio_pkg::phase_t p_phase;
	int               p_hidx;
	logic [31:0]      p_acc;
	logic [6:0][31:0] p_fld;
	logic [31:0]      p_remain;
	int               p_pos;
	logic             p_strip;
	int               p_snl;
	logic             p_tmatch;

	byte_tag_t   pending_tags[$];
	logic [7:0]  name_buf[$];
	logic [31:0] hdr [F_COUNT];
	int sent_bytes;
	int entries;
	int checked = 0;
	int headers_seen = 0;
	int errors = 0;
	int cycles = 0;
	int burst_left;
	int rx_cyc = 0;
	rx_mode_t rx_mode = RX_OPEN;
	byte_tag_t want;

	function automatic logic [3:0] digit_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
		if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
		return 4'd0;
	endfunction

	function automatic int kept_slot(input int f);
		case (f)
			F_INO:      return 0;
			F_MODE:     return 1;
			F_UID:      return 2;
			F_GID:      return 3;
			F_MTIME:    return 4;
			F_FILESIZE: return SL_DATA;
			F_NAMESIZE: return SL_NAME;
			default:    return -1;
		endcase
	endfunction

	function automatic logic [7:0] trailer_byte(input int i);
		return TRAILER_NAME[79 - 8 * i -: 8];
	endfunction

	function automatic logic close_entry();
		if (p_tmatch) begin
			p_phase = cpio_pkg::PH_ENDED;
			return 1'b1;
		end
		p_phase = cpio_pkg::PH_HEADER;
		p_hidx = 0;
		return 1'b0;
	endfunction

	function automatic logic after_data(input int pn);
		if (pn != 0) begin
			p_phase = cpio_pkg::PH_DATAPAD;
			return 1'b0;
		end
		return close_entry();
	endfunction

	function automatic logic start_data(input int pn);
		if (p_fld[SL_DATA] != 0) begin
			p_phase = cpio_pkg::PH_DATA;
			p_remain = p_fld[SL_DATA];
			return 1'b0;
		end
		return after_data(pn);
	endfunction

	function automatic logic after_name(input int pn);
		if (pn != 0) begin
			p_phase = cpio_pkg::PH_NAMEPAD;
			return 1'b0;
		end
		return start_data(pn);
	endfunction

	// advances the predicted parser by one byte and returns the tagged output
	function automatic byte_tag_t parse_byte(input logic [7:0] b);
		byte_tag_t t;
		int pn;
		int rel;
		int s;
		pn = (p_pos + 1) % ALIGN;
		t.data = b;
		t.region = cpio_pkg::RGN_AFTER_END;
		t.last = 1'b0;
		t.hv = 1'b0;
		t.eoa = 1'b0;
		case (p_phase)
			cpio_pkg::PH_HEADER: begin
				t.region = cpio_pkg::RGN_HEADER;
				if (p_hidx >= MAGIC_BYTES) begin
					rel = p_hidx - MAGIC_BYTES;
					p_acc = {p_acc[27:0], digit_of(b)};
					if (rel % 8 == 7) begin
						s = kept_slot(rel / 8);
						if (s >= 0) p_fld[s] = p_acc;
					end
				end
				if (p_hidx >= HDR_BYTES - 1) begin
					t.last = 1'b1;
					t.hv = 1'b1;
					p_hidx = 0;
					p_strip = 1'b1;
					p_snl = 0;
					p_tmatch = (p_fld[SL_NAME] != 0);
					if (p_fld[SL_NAME] != 0) begin
						p_phase = cpio_pkg::PH_NAME;
						p_remain = p_fld[SL_NAME];
					end else begin
						t.eoa = after_name(pn);
					end
				end else begin
					p_hidx++;
				end
			end
			cpio_pkg::PH_NAME: begin
				if (p_remain <= 1) begin
					// last name byte is the terminator whatever its value
					t.region = cpio_pkg::RGN_NAME_TERM;
					t.last = 1'b1;
					if (!(p_tmatch && p_snl == TRAILER_CHARS && b == 8'h00)) p_tmatch = 1'b0;
					p_snl++;
					p_remain = 0;
					t.eoa = after_name(pn);
				end else begin
					if (p_strip && b == SLASH) begin
						t.region = cpio_pkg::RGN_SLASH;
					end else begin
						p_strip = 1'b0;
						t.region = cpio_pkg::RGN_NAME_CHAR;
						if (p_snl >= TRAILER_CHARS || b != trailer_byte(p_snl)) p_tmatch = 1'b0;
						p_snl++;
					end
					t.last = (p_remain == 2);
					p_remain--;
				end
			end
			cpio_pkg::PH_NAMEPAD: begin
				t.region = cpio_pkg::RGN_NAME_PAD;
				if (pn == 0) begin
					t.last = 1'b1;
					t.eoa = start_data(pn);
				end
			end
			cpio_pkg::PH_DATA: begin
				t.region = cpio_pkg::RGN_DATA;
				if (p_remain <= 1) begin
					t.last = 1'b1;
					p_remain = 0;
					t.eoa = after_data(pn);
				end else begin
					p_remain--;
				end
			end
			cpio_pkg::PH_DATAPAD: begin
				t.region = cpio_pkg::RGN_DATA_PAD;
				if (pn == 0) begin
					t.last = 1'b1;
					t.eoa = close_entry();
				end
			end
			default: t.region = cpio_pkg::RGN_AFTER_END;
		endcase
		p_pos = pn;
		t.fld = p_fld;
		return t;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input digit_case_t dc);
		logic upper;
		upper = (dc == CASE_UPPER) || (dc == CASE_MIXED && $urandom_range(1, 0) == 1);
		if (n < 10) return 8'h30 + n;
		return (upper ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] c;
		if ($urandom_range(1, 0) == 1) begin
			// neighbors of the digit and letter ranges
			case ($urandom_range(5, 0))
				0:       c = 8'h2F;
				1:       c = 8'h3A;
				2:       c = 8'h40;
				3:       c = 8'h47;
				4:       c = 8'h60;
				default: c = 8'h67;
			endcase
		end else begin
			do c = 8'($urandom_range(255, 0)); while (digit_of(c) != 0 || c == 8'h30);
		end
		return c;
	endfunction

	task automatic cmp_field(input string what, input logic [31:0] exp_v, input logic [31:0] got);
		if (exp_v !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got);
		end
	endtask

	// one transaction on the input side, bursts separated by random gaps
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(48, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		sent_bytes++;
		pending_tags.push_back(parse_byte(b));
	endtask

	task automatic pad_to_align();
		while (sent_bytes % ALIGN != 0)
			send_byte(($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0)) : 8'h00);
	endtask

	// header from hdr[], name from name_buf, then dlen random data bytes
	task automatic send_entry(input digit_case_t dc, input logic noisy, input logic junk_magic,
			input int dlen);
		logic [3:0] nib;
		logic [7:0] c;
		hdr[F_FILESIZE] = 32'(dlen);
		hdr[F_NAMESIZE] = 32'(name_buf.size());
		for (int i = 0; i < MAGIC_BYTES; i++)
			send_byte(junk_magic ? 8'($urandom_range(255, 0)) : NEWC_MAGIC[47 - 8 * i -: 8]);
		for (int k = 0; k < F_COUNT; k++) begin
			for (int j = 0; j < 8; j++) begin
				nib = hdr[k][31 - 4 * j -: 4];
				c = hex_char(nib, dc);
				// zero digits may be replaced by any byte that decodes as zero
				if (noisy && nib == 4'd0 && $urandom_range(1, 0) == 1) c = rand_nonhex();
				send_byte(c);
			end
		end
		foreach (name_buf[i]) send_byte(name_buf[i]);
		pad_to_align();
		repeat (dlen) send_byte(8'($urandom_range(255, 0)));
		pad_to_align();
		entries++;
	endtask

	task automatic set_name(input string s, input logic [7:0] term);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
		name_buf.push_back(term);
	endtask

	task automatic fill_hdr(input logic [31:0] v);
		for (int k = 0; k < F_COUNT; k++) hdr[k] = v;
	endtask

	task automatic random_hdr();
		for (int k = 0; k < F_COUNT; k++)
			hdr[k] = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 0) : $urandom;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_tags.size() != 0);
	endtask

	task automatic test_plain_entry();
		fill_hdr(32'h0);
		hdr[F_INO] = 32'h0001_2345;
		hdr[F_MODE] = 32'h0000_81A4;
		hdr[F_UID] = 32'd1000;
		hdr[F_GID] = 32'd100;
		hdr[F_NLINK] = 32'd1;
		hdr[F_MTIME] = 32'h6543_21FE;
		set_name("etc/hosts", 8'h00);
		send_entry(CASE_UPPER, 1'b0, 1'b0, 5);
	endtask

	task automatic test_hex_digits();
		fill_hdr(32'h0123_4567);
		hdr[F_MODE] = 32'h89AB_CDEF;
		hdr[F_UID] = 32'hFEDC_BA98;
		set_name("a", 8'h00);
		send_entry(CASE_LOWER, 1'b0, 1'b0, 3);
	endtask

	task automatic test_nonhex_digits();
		fill_hdr(32'h1000_0001);
		set_name("n", 8'h00);
		send_entry(CASE_LOWER, 1'b1, 1'b1, 2);
	endtask

	task automatic test_empty_parts();
		random_hdr();
		name_buf.delete();
		send_entry(CASE_MIXED, 1'b0, 1'b0, 0);   // no name, no data
	endtask

	task automatic test_slash_names();
		random_hdr();
		set_name("///", 8'h00);
		send_entry(CASE_UPPER, 1'b0, 1'b0, 0);
	endtask

	task automatic test_trailer_lookalikes();
		random_hdr();
		set_name("TRAILER!!!", "x");
		send_entry(CASE_UPPER, 1'b0, 1'b0, 0);
	endtask

	// well formed entries with random content, some junk headers
	task automatic test_random_archive();
		int start;
		int nlen;
		int n_entries;
		logic junk;
		start = sent_bytes;
		n_entries = 0;
		while (sent_bytes - start < RANDOM_BYTES) begin
			random_hdr();
			junk = ($urandom_range(9, 0) == 0);
			name_buf.delete();
			if ($urandom_range(9, 0) != 0) begin
				if ($urandom_range(2, 0) == 0)
					repeat ($urandom_range(3, 1)) name_buf.push_back(SLASH);
				nlen = $urandom_range(20, 0);
				repeat (nlen) begin
					case ($urandom_range(9, 0))
						0:       name_buf.push_back(SLASH);
						1:       name_buf.push_back(8'($urandom_range(255, 0)));
						default: name_buf.push_back(8'($urandom_range(8'h7E, 8'h21)));
					endcase
				end
				name_buf.push_back(($urandom_range(6, 0) == 0) ? 8'($urandom_range(255, 0)) : 8'h00);
			end
			send_entry(digit_case_t'($urandom_range(2, 0)), junk || $urandom_range(4, 0) == 0,
				junk, int'(($urandom_range(9, 0) == 0) ? $urandom_range(120, 41)
				: $urandom_range(40, 0)));
			n_entries++;
			// let the whole pipeline drain once mid-archive
			if (n_entries == 1) wait_drained();
		end
	endtask

	task automatic test_archive_end();
		random_hdr();
		set_name("//TRAILER!!!", 8'h00);
		send_entry(CASE_UPPER, 1'b0, 1'b0, 3);
		// everything after the trailer is tagged after-end
		repeat (6) send_byte(8'($urandom_range(255, 0)));
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// receiver stall pattern, mode redrawn at random: open, light, heavy or periodic
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc % 50 == 0) rx_mode <= rx_mode_t'($urandom_range(3, 0));
		case (rx_mode)
			RX_OPEN:  m_axis_tready <= 1'b1;
			RX_LIGHT: m_axis_tready <= ($urandom_range(3, 0) != 0);
			RX_HEAVY: m_axis_tready <= ($urandom_range(3, 0) == 0);
			default:  m_axis_tready <= rx_cyc[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_tags.size() == 0) begin
				errors++;
				$display("%0t: output transaction, expected none, actual byte %h region %0d",
					$time, m_axis_tdata[7:0], m_axis_tuser[2:0]);
			end else begin
				want = pending_tags.pop_front();
				checked++;
				if (m_axis_tuser[3]) headers_seen++;
				cmp_field("byte_out", 32'(want.data), 32'(m_axis_tdata[7:0]));
				cmp_field("region", 32'(want.region), 32'(m_axis_tuser[2:0]));
				cmp_field("last_of_region", 32'(want.last), 32'(m_axis_tlast));
				cmp_field("header_valid", 32'(want.hv), 32'(m_axis_tuser[3]));
				cmp_field("end_of_archive", 32'(want.eoa), 32'(m_axis_tuser[4]));
				cmp_field("inode", want.fld[0], m_axis_tdata[39:8]);
				cmp_field("file_mode", want.fld[1], m_axis_tdata[71:40]);
				cmp_field("owner_id", want.fld[2], m_axis_tdata[103:72]);
				cmp_field("group_id", want.fld[3], m_axis_tdata[135:104]);
				cmp_field("mod_time", want.fld[4], m_axis_tdata[167:136]);
				cmp_field("data_size", want.fld[5], m_axis_tdata[199:168]);
				cmp_field("name_size", want.fld[6], m_axis_tdata[231:200]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d transactions still expected", $time, pending_tags.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		p_phase = cpio_pkg::PH_HEADER;
		p_hidx = 0;
		p_acc = '0;
		p_fld = '0;
		p_remain = '0;
		p_pos = 0;
		p_strip = 1'b1;
		p_snl = 0;
		p_tmatch = 1'b1;
		sent_bytes = 0;
		entries = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_entry();
		test_hex_digits();
		test_nonhex_digits();
		test_empty_parts();
		test_slash_names();
		test_trailer_lookalikes();
		test_random_archive();
		test_archive_end();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Streamed %0d bytes in %0d entries, trailer last; %0d headers decoded.",
			sent_bytes, entries, headers_seen);
		$display("Checked %0d output transactions, %0d mismatches.", checked, errors);
		if (errors == 0 && pending_tags.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
